### hdl/ksp_pkg.sv
// ----------------------------------------------------------------------------
// ksp_pkg: keypoint setpoint profile shared definitions
// Widths, keypoint tables, fuel mapping constants and register indexes.
// ----------------------------------------------------------------------------
package ksp_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int MAX_KEYPOINTS = 7;
    localparam int N_TABLES      = 3;

    localparam int TIME_W = 32;
    localparam int VAL_W  = 9;
    localparam int NUM_W  = TIME_W + VAL_W;
    localparam int DIV_W  = NUM_W + FRAC_BITS;
    localparam int QUO_W  = VAL_W + FRAC_BITS;
    localparam int OUT_W  = 17;
    localparam int KIDX_W = $clog2(MAX_KEYPOINTS);

    localparam int FUEL_GAIN_W = 16;
    localparam int FUEL_SHIFT  = 16;
    localparam int PROD_W      = QUO_W + FUEL_GAIN_W;
    localparam logic [FUEL_GAIN_W-1:0] FUEL_GAIN = 16'd59205;
    localparam int unsigned FUEL_OFFSET = ((1232 << FRAC_BITS) + 50) / 100;
    localparam logic [OUT_W-1:0] SETPOINT_MAX = 17'h1FFFF;

    localparam logic [TIME_W-1:0] DURATION_RESET = 32'd15000000;

    // profile selector codes
    localparam logic [1:0] SEL_THROTTLED = 2'd0;
    localparam logic [1:0] SEL_NOMINAL   = 2'd1;
    localparam logic [1:0] SEL_FLOW      = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PROFILE_SELECT = 2'd0;
    localparam logic [1:0] CFG_FUEL_SIDE      = 2'd1;
    localparam logic [1:0] CFG_FLOW_DURATION  = 2'd2;

    localparam int KEY_COUNT [N_TABLES] = '{7, 5, 7};

    localparam logic [TIME_W-1:0] KEY_TIME [N_TABLES][MAX_KEYPOINTS] = '{
        '{32'd0, 32'd1500000, 32'd4000000, 32'd7000000, 32'd11000000, 32'd13000000, 32'd0},
        '{32'd0, 32'd400000,  32'd3000000, 32'd6000000, 32'd0,        32'd0,        32'd0},
        '{32'd0, 32'd1500000, 32'd4000000, 32'd7000000, 32'd11000000, 32'd13000000, 32'd0}
    };

    localparam logic [VAL_W-1:0] KEY_VAL [N_TABLES][MAX_KEYPOINTS] = '{
        '{9'd0, 9'd350, 9'd350, 9'd480, 9'd480, 9'd250, 9'd250},
        '{9'd0, 9'd120, 9'd120, 9'd240, 9'd240, 9'd0,   9'd0},
        '{9'd0, 9'd11,  9'd11,  9'd12,  9'd12,  9'd10,  9'd10}
    };

    typedef struct packed {
        logic ended;
        logic fuel;
    } t_side;

endpackage

### hdl/keypoint_setpoint_profile.sv
// ----------------------------------------------------------------------------
// keypoint_setpoint_profile: keypoint setpoint profile top level
// Piecewise linear setpoint versus elapsed flow time with fuel mapping.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  input     in         i_valid / o_stall              i_flow_time
//  output    out        o_valid / i_stall              o_setpoint, o_flow_ended
//  config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  One request per cycle while o_stall is low; the divider resolves one
//  quotient bit per stage.
//  Reset clears all valid bits and loads selector 0, fuel side 0 and a
//  15 s flow duration.
//  An output register and a one-entry skid buffer follow the pipeline; o_stall
//  is the registered skid-full flag and freezes every stage while set.
// ----------------------------------------------------------------------------
module keypoint_setpoint_profile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ksp_pkg::TIME_W-1:0]      i_flow_time,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ksp_pkg::OUT_W-1:0]       o_setpoint,
    output logic                            o_flow_ended,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    logic [1:0]                     r_sel;
    logic                           r_fuel;
    logic [ksp_pkg::TIME_W-1:0]     r_dur;

    logic                           en;

    logic                           seg_v;
    logic [ksp_pkg::TIME_W-1:0]     seg_w;
    logic [ksp_pkg::TIME_W-1:0]     seg_dt;
    logic [ksp_pkg::TIME_W-1:0]     seg_span;
    logic [ksp_pkg::VAL_W-1:0]      seg_v0;
    logic [ksp_pkg::VAL_W-1:0]      seg_v1;
    ksp_pkg::t_side                 seg_side;

    logic                           itp_v;
    logic [ksp_pkg::NUM_W-1:0]      itp_num;
    logic [ksp_pkg::TIME_W-1:0]     itp_span;
    ksp_pkg::t_side                 itp_side;

    logic                           div_v;
    logic [ksp_pkg::QUO_W-1:0]      div_quo;
    ksp_pkg::t_side                 div_side;

    logic                           c_v;
    logic [ksp_pkg::OUT_W-1:0]      c_sp;
    logic                           c_end;

    logic                           r_out_v;
    logic [ksp_pkg::OUT_W-1:0]      r_out_sp;
    logic                           r_out_end;
    logic                           r_skid_v;
    logic [ksp_pkg::OUT_W-1:0]      r_skid_sp;
    logic                           r_skid_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= ksp_pkg::SEL_THROTTLED;
            r_fuel <= 1'b0;
            r_dur  <= ksp_pkg::DURATION_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ksp_pkg::CFG_PROFILE_SELECT: r_sel  <= i_cfg_data[1:0];
                ksp_pkg::CFG_FUEL_SIDE:      r_fuel <= i_cfg_data[0];
                ksp_pkg::CFG_FLOW_DURATION:  r_dur  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the skid holds a result
    assign en      = ~r_skid_v;
    assign o_stall = r_skid_v;

    ksp_seg u_seg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_flow_time (i_flow_time),
        .i_sel       (r_sel),
        .i_fuel_side (r_fuel),
        .i_duration  (r_dur),
        .o_valid     (seg_v),
        .o_w         (seg_w),
        .o_dt        (seg_dt),
        .o_span      (seg_span),
        .o_v0        (seg_v0),
        .o_v1        (seg_v1),
        .o_side      (seg_side)
    );

    ksp_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (seg_v),
        .i_w     (seg_w),
        .i_dt    (seg_dt),
        .i_span  (seg_span),
        .i_v0    (seg_v0),
        .i_v1    (seg_v1),
        .i_side  (seg_side),
        .o_valid (itp_v),
        .o_num   (itp_num),
        .o_span  (itp_span),
        .o_side  (itp_side)
    );

    ksp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (itp_v),
        .i_num   (itp_num),
        .i_span  (itp_span),
        .i_side  (itp_side),
        .o_valid (div_v),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    ksp_fuel u_fuel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (div_v),
        .i_quo        (div_quo),
        .i_side       (div_side),
        .o_valid      (c_v),
        .o_setpoint   (c_sp),
        .o_flow_ended (c_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out_v <= c_v;
        end else if (c_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_stall) begin
                r_out_sp  <= r_skid_sp;
                r_out_end <= r_skid_end;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out_sp  <= c_sp;
            r_out_end <= c_end;
        end else begin
            // park the arriving result behind the held one
            r_skid_sp  <= c_sp;
            r_skid_end <= c_end;
        end
    end

    assign o_valid      = r_out_v;
    assign o_setpoint   = r_out_sp;
    assign o_flow_ended = r_out_end;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall && c_v))
        else $error("skid filled without a held output and an arriving result");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_stall) |=> (r_skid_v && $stable(r_skid_sp)))
        else $error("skid content lost under stall");

    a_ended_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_flow_ended) |->
            (o_setpoint == '0 ||
             o_setpoint == ksp_pkg::OUT_W'(ksp_pkg::FUEL_OFFSET)))
        else $error("setpoint after flow end is neither zero nor the fuel offset");

endmodule

### hdl/ksp_seg.sv
// ----------------------------------------------------------------------------
// ksp_seg: segment lookup
// Finds the keypoint segment around the flow time, then forms span and
// the two interpolation weights.
// ----------------------------------------------------------------------------
module ksp_seg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [ksp_pkg::TIME_W-1:0]      i_flow_time,
    input  logic [1:0]                      i_sel,
    input  logic                            i_fuel_side,
    input  logic [ksp_pkg::TIME_W-1:0]      i_duration,
    output logic                            o_valid,
    output logic [ksp_pkg::TIME_W-1:0]      o_w,
    output logic [ksp_pkg::TIME_W-1:0]      o_dt,
    output logic [ksp_pkg::TIME_W-1:0]      o_span,
    output logic [ksp_pkg::VAL_W-1:0]       o_v0,
    output logic [ksp_pkg::VAL_W-1:0]       o_v1,
    output ksp_pkg::t_side                  o_side
);

    logic [1:0]                     sel;
    logic [ksp_pkg::KIDX_W-1:0]     idx;
    logic                           found;
    logic [ksp_pkg::TIME_W-1:0]     n_t0;
    logic [ksp_pkg::TIME_W-1:0]     n_t1;
    logic [ksp_pkg::VAL_W-1:0]      n_v0;
    logic [ksp_pkg::VAL_W-1:0]      n_v1;
    ksp_pkg::t_side                 n_side;

    logic                           r_a_v;
    logic [ksp_pkg::TIME_W-1:0]     r_a_t;
    logic [ksp_pkg::TIME_W-1:0]     r_a_t0;
    logic [ksp_pkg::TIME_W-1:0]     r_a_t1;
    logic [ksp_pkg::VAL_W-1:0]      r_a_v0;
    logic [ksp_pkg::VAL_W-1:0]      r_a_v1;
    ksp_pkg::t_side                 r_a_side;

    logic                           r_b_v;
    logic [ksp_pkg::TIME_W-1:0]     r_b_w;
    logic [ksp_pkg::TIME_W-1:0]     r_b_dt;
    logic [ksp_pkg::TIME_W-1:0]     r_b_span;
    logic [ksp_pkg::VAL_W-1:0]      r_b_v0;
    logic [ksp_pkg::VAL_W-1:0]      r_b_v1;
    ksp_pkg::t_side                 r_b_side;

    assign sel = (i_sel > ksp_pkg::SEL_FLOW) ? ksp_pkg::SEL_THROTTLED : i_sel;

    // first segment whose end time is not below the flow time
    always_comb begin
        found = 1'b0;
        idx   = ksp_pkg::KIDX_W'(1);
        for (int i = ksp_pkg::MAX_KEYPOINTS - 1; i >= 1; i--) begin
            if (i < ksp_pkg::KEY_COUNT[sel]) begin
                if (i_flow_time <= ((i + 1 == ksp_pkg::KEY_COUNT[sel]) ?
                                    i_duration : ksp_pkg::KEY_TIME[sel][i])) begin
                    found = 1'b1;
                    idx   = ksp_pkg::KIDX_W'(i);
                end
            end
        end
    end

    always_comb begin
        n_t0 = ksp_pkg::KEY_TIME[sel][idx - 1'b1];
        n_t1 = (32'(idx) + 32'd1 == 32'(ksp_pkg::KEY_COUNT[sel])) ?
               i_duration : ksp_pkg::KEY_TIME[sel][idx];
        n_v0 = ksp_pkg::KEY_VAL[sel][idx - 1'b1];
        n_v1 = ksp_pkg::KEY_VAL[sel][idx];
        n_side.ended = ~found;
        n_side.fuel  = (sel != ksp_pkg::SEL_FLOW) && i_fuel_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_t    <= i_flow_time;
            r_a_t0   <= n_t0;
            r_a_t1   <= n_t1;
            r_a_v0   <= n_v0;
            r_a_v1   <= n_v1;
            r_a_side <= n_side;
            // past the last keypoint: zero weights and a unit span give zero
            if (r_a_side.ended) begin
                r_b_w    <= '0;
                r_b_dt   <= '0;
                r_b_span <= ksp_pkg::TIME_W'(1);
            end else begin
                r_b_w    <= r_a_t1 - r_a_t;
                r_b_dt   <= r_a_t - r_a_t0;
                r_b_span <= r_a_t1 - r_a_t0;
            end
            r_b_v0   <= r_a_v0;
            r_b_v1   <= r_a_v1;
            r_b_side <= r_a_side;
        end
    end

    assign o_valid = r_b_v;
    assign o_w     = r_b_w;
    assign o_dt    = r_b_dt;
    assign o_span  = r_b_span;
    assign o_v0    = r_b_v0;
    assign o_v1    = r_b_v1;
    assign o_side  = r_b_side;

endmodule

### hdl/ksp_interp.sv
// ----------------------------------------------------------------------------
// ksp_interp: weighted sum
// Multiplies both keypoint values by their weights and sums them into the
// interpolation numerator.
// ----------------------------------------------------------------------------
module ksp_interp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [ksp_pkg::TIME_W-1:0]      i_w,
    input  logic [ksp_pkg::TIME_W-1:0]      i_dt,
    input  logic [ksp_pkg::TIME_W-1:0]      i_span,
    input  logic [ksp_pkg::VAL_W-1:0]       i_v0,
    input  logic [ksp_pkg::VAL_W-1:0]       i_v1,
    input  ksp_pkg::t_side                  i_side,
    output logic                            o_valid,
    output logic [ksp_pkg::NUM_W-1:0]       o_num,
    output logic [ksp_pkg::TIME_W-1:0]      o_span,
    output ksp_pkg::t_side                  o_side
);

    logic                           r_c_v;
    logic [ksp_pkg::NUM_W-1:0]      r_c_p0;
    logic [ksp_pkg::NUM_W-1:0]      r_c_p1;
    logic [ksp_pkg::TIME_W-1:0]     r_c_span;
    ksp_pkg::t_side                 r_c_side;

    logic                           r_d_v;
    logic [ksp_pkg::NUM_W-1:0]      r_d_num;
    logic [ksp_pkg::TIME_W-1:0]     r_d_span;
    ksp_pkg::t_side                 r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= i_valid;
            r_d_v <= r_c_v;
        end
    end

    // the sum never exceeds the larger value times the span
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_p0   <= ksp_pkg::NUM_W'(i_v0) * ksp_pkg::NUM_W'(i_w);
            r_c_p1   <= ksp_pkg::NUM_W'(i_v1) * ksp_pkg::NUM_W'(i_dt);
            r_c_span <= i_span;
            r_c_side <= i_side;
            r_d_num  <= r_c_p0 + r_c_p1;
            r_d_span <= r_c_span;
            r_d_side <= r_c_side;
        end
    end

    assign o_valid = r_d_v;
    assign o_num   = r_d_num;
    assign o_span  = r_d_span;
    assign o_side  = r_d_side;

endmodule

### hdl/ksp_div.sv
// ----------------------------------------------------------------------------
// ksp_div: pipelined restoring divider
// Divides the scaled numerator by the span, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ksp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [ksp_pkg::NUM_W-1:0]       i_num,
    input  logic [ksp_pkg::TIME_W-1:0]      i_span,
    input  ksp_pkg::t_side                  i_side,
    output logic                            o_valid,
    output logic [ksp_pkg::QUO_W-1:0]       o_quo,
    output ksp_pkg::t_side                  o_side
);

    logic                           r_v    [ksp_pkg::QUO_W];
    logic [ksp_pkg::DIV_W-1:0]      r_rem  [ksp_pkg::QUO_W];
    logic [ksp_pkg::TIME_W-1:0]     r_dvs  [ksp_pkg::QUO_W];
    logic [ksp_pkg::QUO_W-1:0]      r_quo  [ksp_pkg::QUO_W];
    ksp_pkg::t_side                 r_side [ksp_pkg::QUO_W];

    logic                           s_v    [ksp_pkg::QUO_W];
    logic [ksp_pkg::DIV_W-1:0]      s_rem  [ksp_pkg::QUO_W];
    logic [ksp_pkg::TIME_W-1:0]     s_dvs  [ksp_pkg::QUO_W];
    logic [ksp_pkg::QUO_W-1:0]      s_quo  [ksp_pkg::QUO_W];
    ksp_pkg::t_side                 s_side [ksp_pkg::QUO_W];

    for (genvar k = 0; k < ksp_pkg::QUO_W; k++) begin : g_stage
        localparam int BIT = ksp_pkg::QUO_W - 1 - k;

        logic [ksp_pkg::DIV_W-1:0]  trial;
        logic                       fits;

        if (k == 0) begin : g_first
            assign s_v[k]    = i_valid;
            assign s_rem[k]  = {i_num, {ksp_pkg::FRAC_BITS{1'b0}}};
            assign s_dvs[k]  = i_span;
            assign s_quo[k]  = '0;
            assign s_side[k] = i_side;
        end else begin : g_next
            assign s_v[k]    = r_v[k-1];
            assign s_rem[k]  = r_rem[k-1];
            assign s_dvs[k]  = r_dvs[k-1];
            assign s_quo[k]  = r_quo[k-1];
            assign s_side[k] = r_side[k-1];
        end

        assign trial = ksp_pkg::DIV_W'(s_dvs[k]) << BIT;
        assign fits  = s_rem[k] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]     <= fits ? (s_rem[k] - trial) : s_rem[k];
                r_quo[k]     <= s_quo[k] | (ksp_pkg::QUO_W'(fits) << BIT);
                r_dvs[k]     <= s_dvs[k];
                r_side[k]    <= s_side[k];
            end
        end
    end

    assign o_valid = r_v[ksp_pkg::QUO_W-1];
    assign o_quo   = r_quo[ksp_pkg::QUO_W-1];
    assign o_side  = r_side[ksp_pkg::QUO_W-1];

endmodule

### hdl/ksp_fuel.sv
// ----------------------------------------------------------------------------
// ksp_fuel: fuel side mapping
// Applies gain and offset on the fuel side and saturates the setpoint.
// ----------------------------------------------------------------------------
module ksp_fuel (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [ksp_pkg::QUO_W-1:0]       i_quo,
    input  ksp_pkg::t_side                  i_side,
    output logic                            o_valid,
    output logic [ksp_pkg::OUT_W-1:0]       o_setpoint,
    output logic                            o_flow_ended
);

    logic                           r_e_v;
    logic [ksp_pkg::PROD_W-1:0]     r_e_prod;
    logic [ksp_pkg::QUO_W-1:0]      r_e_quo;
    ksp_pkg::t_side                 r_e_side;

    logic                           r_f_v;
    logic [ksp_pkg::OUT_W-1:0]      r_f_sp;
    logic                           r_f_end;

    logic [31:0]                    sum;
    logic [ksp_pkg::OUT_W-1:0]      n_sp;

    always_comb begin
        if (r_e_side.fuel) begin
            sum = 32'(r_e_prod >> ksp_pkg::FUEL_SHIFT) + 32'(ksp_pkg::FUEL_OFFSET);
        end else begin
            sum = 32'(r_e_quo);
        end
        n_sp = (sum > 32'(ksp_pkg::SETPOINT_MAX)) ? ksp_pkg::SETPOINT_MAX :
               ksp_pkg::OUT_W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_e_v <= i_valid;
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_prod <= ksp_pkg::PROD_W'(i_quo) * ksp_pkg::PROD_W'(ksp_pkg::FUEL_GAIN);
            r_e_quo  <= i_quo;
            r_e_side <= i_side;
            r_f_sp   <= n_sp;
            r_f_end  <= r_e_side.ended;
        end
    end

    assign o_valid      = r_f_v;
    assign o_setpoint   = r_f_sp;
    assign o_flow_ended = r_f_end;

endmodule

### test/tb_keypoint_setpoint_profile.sv
// ----------------------------------------------------------------------------
// tb_keypoint_setpoint_profile: self-checking bench for the setpoint profile
// Drives flow times through the valid/stall channel under several register
// settings, predicts every interpolated setpoint and checks the results in
// order while both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_keypoint_setpoint_profile;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SHIFT_FX   = 8;
    localparam logic [63:0] GAIN_Q16   = 64'd59205;
    localparam logic [63:0] OFFSET_FX  = 64'd3154;
    localparam logic [63:0] SAT_FX     = 64'd131071;
    localparam logic [1:0]  CFG_UNUSED = 2'd3;
    localparam logic [1:0]  SEL_UNUSED = 2'd3;
    localparam int          QUIET_MAX  = 4000;
    localparam int          TAIL_WAIT  = 40;

    typedef enum logic [1:0] {ACT_SAMPLE, ACT_WRITE, ACT_SETTLE} t_act_kind;

    typedef struct {
        t_act_kind   kind;
        logic [1:0]  idx;
        logic [31:0] data;
        int          gap;
        bit          calm;
    } t_act;

    typedef struct packed {
        logic [ksp_pkg::TIME_W-1:0] flow_time;
        logic [ksp_pkg::OUT_W-1:0]  setpoint;
        logic                       ended;
    } t_result;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_valid      = 1'b0;
    logic [ksp_pkg::TIME_W-1:0]   i_flow_time  = '0;
    logic                         i_stall      = 1'b0;
    logic                         i_cfg_valid  = 1'b0;
    logic [1:0]                   i_cfg_index  = '0;
    logic [31:0]                  i_cfg_data   = '0;
    logic                         o_stall;
    logic                         o_valid;
    logic [ksp_pkg::OUT_W-1:0]    o_setpoint;
    logic                         o_flow_ended;
    logic                         o_cfg_ready;

    t_act      pending[$];
    t_result   setpoint_due[$];
    int        requests_sent   = 0;
    int        results_checked = 0;
    int        errors          = 0;
    int        quiet_cycles    = 0;
    int        stall_left      = 0;
    bit        rx_calm         = 1'b0;
    int        gen_count       = 0;
    bit        gen_final       = 1'b0;

    // register copies as the block should hold them
    logic [1:0]  cur_sel  = ksp_pkg::SEL_THROTTLED;
    logic        cur_fuel = 1'b0;
    logic [31:0] cur_dur  = 32'd15000000;

    keypoint_setpoint_profile dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_flow_time  (i_flow_time),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_setpoint   (o_setpoint),
        .o_flow_ended (o_flow_ended),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int last_knot(input logic [1:0] sel);
        return (sel == ksp_pkg::SEL_NOMINAL) ? 4 : 6;
    endfunction

    function automatic logic [31:0] knot_time(input logic [1:0] sel, input int k,
                                              input logic [31:0] dur);
        if (k == last_knot(sel)) return dur;
        if (sel == ksp_pkg::SEL_NOMINAL) begin
            case (k)
                1: return 32'd400000;
                2: return 32'd3000000;
                3: return 32'd6000000;
                default: return 32'd0;
            endcase
        end
        case (k)
            1: return 32'd1500000;
            2: return 32'd4000000;
            3: return 32'd7000000;
            4: return 32'd11000000;
            5: return 32'd13000000;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [63:0] knot_value(input logic [1:0] sel, input int k);
        if (k == 0) return 64'd0;
        case (sel)
            ksp_pkg::SEL_NOMINAL: return (k <= 2) ? 64'd120 : 64'd240;
            ksp_pkg::SEL_FLOW:    return (k <= 2) ? 64'd11 : (k <= 4) ? 64'd12 : 64'd10;
            default:     return (k <= 2) ? 64'd350 : (k <= 4) ? 64'd480 : 64'd250;
        endcase
    endfunction

    function automatic t_result predict_setpoint(input logic [31:0] t);
        logic [1:0]  sel;
        logic [63:0] t0, t1, span, dt, num, v;
        bit          found;
        t_result     r;
        sel   = (cur_sel > ksp_pkg::SEL_FLOW) ? ksp_pkg::SEL_THROTTLED : cur_sel;
        v     = 64'd0;
        found = 1'b0;
        for (int k = 1; k <= last_knot(sel); k++) begin
            t1 = knot_time(sel, k, cur_dur);
            if (!found && t <= t1) begin
                found = 1'b1;
                t0    = knot_time(sel, k - 1, cur_dur);
                span  = t1 - t0;
                dt    = t - t0;
                num   = knot_value(sel, k - 1) * (span - dt) + knot_value(sel, k) * dt;
                if (span == 0) span = 64'd1;
                v = (num << SHIFT_FX) / span;
            end
        end
        // fuel mapping applies to pressure tables only
        if (sel != ksp_pkg::SEL_FLOW && cur_fuel) v = ((v * GAIN_Q16) >> 16) + OFFSET_FX;
        if (v > SAT_FX) v = SAT_FX;
        r.flow_time = t;
        r.setpoint  = v[ksp_pkg::OUT_W-1:0];
        r.ended     = !found;
        return r;
    endfunction

    function automatic logic [31:0] pick_time(input logic [1:0] sel_raw, input logic [31:0] dur);
        logic [1:0]  sel;
        logic [63:0] span;
        int          k;
        sel = (sel_raw > ksp_pkg::SEL_FLOW) ? ksp_pkg::SEL_THROTTLED : sel_raw;
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2, 3, 4: begin
                // land on or next to a keypoint, wrapping below zero
                k = $urandom_range(0, last_knot(sel));
                return knot_time(sel, k, dur) + $urandom_range(0, 6) - 3;
            end
            default: begin
                span = dur + dur / 8;
                if (span < 64'd16000000) span = 64'd16000000;
                if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
                return $urandom_range(0, span[31:0]);
            end
        endcase
    endfunction

    task automatic add_sample(input logic [31:0] t);
        t_act a;
        a.kind = ACT_SAMPLE;
        a.idx  = '0;
        a.data = t;
        a.calm = gen_final || ((gen_count / 64) % 4 == 3);
        a.gap  = (!a.calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
        pending.push_back(a);
        gen_count++;
    endtask

    task automatic add_write(input logic [1:0] idx, input logic [31:0] data);
        t_act a;
        a.kind = ACT_WRITE;
        a.idx  = idx;
        a.data = data;
        a.gap  = gen_final ? 0 : $urandom_range(0, 3);
        a.calm = gen_final;
        pending.push_back(a);
    endtask

    task automatic add_settle();
        t_act a;
        a.kind = ACT_SETTLE;
        a.idx  = '0;
        a.data = '0;
        a.gap  = 0;
        a.calm = gen_final;
        pending.push_back(a);
    endtask

    task automatic add_phase(input logic [1:0] sel, input logic fuel, input logic [31:0] dur,
                             input int n, input bit settle_mid);
        // unused data bits carry noise
        add_write(ksp_pkg::CFG_PROFILE_SELECT, ($urandom & 32'hFFFF_FFFC) | {30'd0, sel});
        add_write(ksp_pkg::CFG_FUEL_SIDE, ($urandom & 32'hFFFF_FFFE) | {31'd0, fuel});
        add_write(ksp_pkg::CFG_FLOW_DURATION, dur);
        for (int j = 0; j < n; j++) begin
            if (settle_mid && j == n / 2) add_settle();
            add_sample(pick_time(sel, dur));
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_requests
        logic nv, ncv;
        t_act head;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nv  = i_valid;
            ncv = i_cfg_valid;
            if (i_valid && !o_stall) begin
                setpoint_due.push_back(predict_setpoint(i_flow_time));
                requests_sent++;
                nv = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ksp_pkg::CFG_PROFILE_SELECT: cur_sel  = i_cfg_data[1:0];
                    ksp_pkg::CFG_FUEL_SIDE:      cur_fuel = i_cfg_data[0];
                    ksp_pkg::CFG_FLOW_DURATION:  cur_dur  = i_cfg_data;
                    default: ;
                endcase
                ncv = 1'b0;
            end
            if (!nv && !ncv && pending.size() > 0) begin
                head = pending[0];
                if (head.gap > 0) begin
                    head.gap--;
                    pending[0] = head;
                end else begin
                    case (head.kind)
                        ACT_SAMPLE: begin
                            nv = 1'b1;
                            i_flow_time <= head.data;
                            rx_calm     <= head.calm;
                            void'(pending.pop_front());
                        end
                        ACT_WRITE: begin
                            // write only with nothing in flight
                            if (requests_sent == results_checked) begin
                                ncv = 1'b1;
                                i_cfg_index <= head.idx;
                                i_cfg_data  <= head.data;
                                void'(pending.pop_front());
                            end
                        end
                        default: begin
                            if (requests_sent == results_checked) void'(pending.pop_front());
                        end
                    endcase
                end
            end
            i_valid     <= nv;
            i_cfg_valid <= ncv;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (setpoint_due.size() == 0) begin
                    $error("unexpected result: setpoint %0d flow_ended %0d",
                           o_setpoint, o_flow_ended);
                    errors++;
                end else begin
                    want = setpoint_due.pop_front();
                    if (o_setpoint !== want.setpoint) begin
                        $error("setpoint (time %0d): expected %0d, actual %0d",
                               want.flow_time, want.setpoint, o_setpoint);
                        errors++;
                    end
                    if (o_flow_ended !== want.ended) begin
                        $error("flow_ended (time %0d): expected %0d, actual %0d",
                               want.flow_time, want.ended, o_flow_ended);
                        errors++;
                    end
                    results_checked <= results_checked + 1;
                end
            end
            if (stall_left > 0) stall_left--;
            else if (!rx_calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 18);
            i_stall <= (stall_left > 0);
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (i_cfg_valid && o_cfg_ready) || (o_valid && !i_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // reset values first, with keypoint edges and field extremes
        add_sample(32'd0);
        add_sample(32'd1);
        add_sample(32'd750000);
        add_sample(32'd1499999);
        add_sample(32'd1500000);
        add_sample(32'd1500001);
        add_sample(32'd4000000);
        add_sample(32'd5500000);
        add_sample(32'd7000000);
        add_sample(32'd11000000);
        add_sample(32'd12999999);
        add_sample(32'd13000000);
        add_sample(32'd13000001);
        add_sample(32'd14999999);
        add_sample(32'd15000000);
        add_sample(32'd15000001);
        add_sample(32'h7FFF_FFFF);
        add_sample(32'h8000_0000);
        add_sample(32'hAAAA_AAAA);
        add_sample(32'h5555_5555);
        add_sample(32'hFFFF_FFFF);
        for (int j = 0; j < 100; j++)
            add_sample(pick_time(ksp_pkg::SEL_THROTTLED, 32'd15000000));

        add_phase(ksp_pkg::SEL_THROTTLED, 1'b1, 32'd15000000, 125, 1'b0);
        add_phase(ksp_pkg::SEL_NOMINAL,   1'b0, 32'd13000001, 125, 1'b0);
        add_phase(ksp_pkg::SEL_NOMINAL,   1'b1, 32'hFFFF_FFFF, 125, 1'b1);
        add_phase(ksp_pkg::SEL_FLOW,      1'b0, 32'd20000000, 125, 1'b0);
        // fuel side has no effect on flow rate
        add_phase(ksp_pkg::SEL_FLOW,      1'b1, 32'd13000001, 125, 1'b0);
        // unused selector behaves as the throttled table
        add_phase(SEL_UNUSED,             1'b0, 32'd15000000, 125, 1'b0);
        add_phase(SEL_UNUSED,             1'b1, 32'hFFFF_FFFF, 125, 1'b0);
        // duration below the previous keypoint ends the flow early
        add_write(CFG_UNUSED, $urandom);
        add_phase(ksp_pkg::SEL_THROTTLED, 1'b0, 32'd12000000, 125, 1'b1);
        add_phase(ksp_pkg::SEL_NOMINAL,   1'b1, 32'd5000000, 125, 1'b0);
        add_phase(ksp_pkg::SEL_THROTTLED, 1'b1, 32'd0, 125, 1'b0);
        add_phase(ksp_pkg::SEL_FLOW,      1'b0, 32'd13000000, 125, 1'b0);
        add_phase(ksp_pkg::SEL_NOMINAL,   1'b0, 32'd6000000, 125, 1'b0);
        add_phase(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  32'($urandom_range(13000001, 60000000)), 125, 1'b0);
        gen_final = 1'b1;
        add_phase(ksp_pkg::SEL_THROTTLED, 1'b0, 32'd30000000, 125, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending.size() != 0 || i_valid || i_cfg_valid || requests_sent != results_checked);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (setpoint_due.size() != 0) begin
            $error("%0d results never arrived", setpoint_due.size());
            errors++;
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
